@@ design/tgsr_pkg.sv @@
`default_nettype none

package tgsr_pkg;

   // Field widths of the request and response payloads.
   localparam int CMD_W   = 3;
   localparam int COORD_W = 6;
   localparam int TILE_W  = 17;
   localparam int SHIFT_W = 8;
   localparam int SIZE_W  = 7;

   // Command codes carried in the cmd field.
   localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SHIFT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RESIZE = 3'd4;

   // An empty cell holds -1.
   localparam logic [TILE_W-1:0] EMPTY_TILE = '1;

   // Main sequencer states.
   typedef enum logic [5:0] {
      ST_INIT  = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_SETUP = 6'b000100,
      ST_SHIFT = 6'b001000,
      ST_DRAIN = 6'b010000,
      ST_FILL  = 6'b100000
   } state_type;

   // Controls from the sequencer to the source walker.
   typedef struct packed {
      logic load;
      logic start;
      logic step;
      logic row_end;
   } walk_ctl_type;

   // Status from the source walker back to the sequencer.
   typedef struct packed {
      logic settled;
      logic src_ok;
   } walk_stat_type;

endpackage

`default_nettype wire

@@ design/tgsr_req_if.sv @@
`default_nettype none

interface tgsr_req_if import tgsr_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          cmd;
   logic [COORD_W-1:0]        row;
   logic [COORD_W-1:0]        col;
   logic signed [TILE_W-1:0]  tile_in;
   logic signed [SHIFT_W-1:0] shift_x;
   logic signed [SHIFT_W-1:0] shift_y;
   logic                      wrap;
   logic [SIZE_W-1:0]         new_width;
   logic [SIZE_W-1:0]         new_height;
   logic                      keep;

   modport source (
      output valid, cmd, row, col, tile_in, shift_x, shift_y, wrap,
             new_width, new_height, keep,
      input  ready
   );

   modport sink (
      input  valid, cmd, row, col, tile_in, shift_x, shift_y, wrap,
             new_width, new_height, keep,
      output ready
   );
endinterface

`default_nettype wire

@@ design/tgsr_rsp_if.sv @@
`default_nettype none

interface tgsr_rsp_if import tgsr_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [TILE_W-1:0] tile_out;
   logic                     in_bounds;
   logic                     done_res;

   modport source (
      output valid, tile_out, in_bounds, done_res,
      input  ready
   );

   modport sink (
      input  valid, tile_out, in_bounds, done_res,
      output ready
   );
endinterface

`default_nettype wire

@@ design/tgsr_src_walk.sv @@
`default_nettype none

// Walks the source coordinates of a shift in step with the destination sweep.
// Before the sweep, the start offsets are brought into range for a wrapping
// shift by repeated add or subtract of the grid size, one step per cycle.
module tgsr_src_walk import tgsr_pkg::*; #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  logic                      clock,
   input  walk_ctl_type              ctl,
   input  logic                      wrap,
   input  logic signed [SHIFT_W-1:0] shift_x,
   input  logic signed [SHIFT_W-1:0] shift_y,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]  width,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0] height,
   output walk_stat_type             stat,
   output logic [((MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1)-1:0] src_col,
   output logic [((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1)-1:0] src_row
);

   localparam int CB = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
   localparam int RB = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int XW = ((CB > SHIFT_W - 1) ? CB : SHIFT_W - 1) + 2;
   localparam int YW = ((RB > SHIFT_W - 1) ? RB : SHIFT_W - 1) + 2;

   logic                 wrap_ff;
   logic signed [XW-1:0] x0_ff;
   logic signed [YW-1:0] y0_ff;
   logic signed [XW-1:0] x_ff;
   logic signed [YW-1:0] y_ff;
   logic signed [XW-1:0] w_s;
   logic signed [YW-1:0] h_s;
   logic signed [XW-1:0] x_inc;
   logic signed [YW-1:0] y_inc;
   logic                 x0_ok;
   logic                 y0_ok;

   assign w_s   = XW'(width);
   assign h_s   = YW'(height);
   assign x_inc = x_ff + XW'(1);
   assign y_inc = y_ff + YW'(1);

   // The start offsets are settled once both lie inside the grid, or at once without wrap.
   assign x0_ok = !x0_ff[XW-1] && (x0_ff < w_s);
   assign y0_ok = !y0_ff[YW-1] && (y0_ff < h_s);
   assign stat.settled = !wrap_ff || (x0_ok && y0_ok);

   // Without wrap, a source outside the grid leaves the cell empty.
   assign stat.src_ok = wrap_ff ||
                        (!x_ff[XW-1] && (x_ff < w_s) && !y_ff[YW-1] && (y_ff < h_s));

   assign src_col = x_ff[CB-1:0];
   assign src_row = y_ff[RB-1:0];

   // Start offsets: load the negated shift, then reduce it modulo the size.
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         wrap_ff <= wrap;
         x0_ff   <= -(XW'(shift_x));
         y0_ff   <= -(YW'(shift_y));
      end else if (!stat.settled) begin
         if (x0_ff[XW-1]) begin
            x0_ff <= x0_ff + w_s;
         end else if (!x0_ok) begin
            x0_ff <= x0_ff - w_s;
         end
         if (y0_ff[YW-1]) begin
            y0_ff <= y0_ff + h_s;
         end else if (!y0_ok) begin
            y0_ff <= y0_ff - h_s;
         end
      end
   end

   // Source position follows the destination sweep in row-major order.
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         x_ff <= x0_ff;
         y_ff <= y0_ff;
      end else if (ctl.step) begin
         if (ctl.row_end) begin
            x_ff <= x0_ff;
            y_ff <= (wrap_ff && (y_inc == h_s)) ? '0 : y_inc;
         end else begin
            x_ff <= (wrap_ff && (x_inc == w_s)) ? '0 : x_inc;
         end
      end
   end

endmodule

`default_nettype wire

@@ design/tile_grid_shift_resize.sv @@
// Channel   Direction  Handshake          Carries
// req_bus   in         valid/ready        cmd, row, col, tile_in, shift, wrap, size, keep
// rsp_bus   out        valid/ready        tile_out, in_bounds, done_res
//
// Write, read and unused codes are taken one per cycle unless the result port stalls; a
// result passes through the registered read of the grid memory, then the output register.
// Clear and a resize that changes the size hold off requests while they sweep all
// MAX_WIDTH*MAX_HEIGHT cells, one cell per cycle; a resize to the same size skips the sweep.
// Shift first settles the wrap offsets in a setup state, then sweeps all MAX_WIDTH*MAX_HEIGHT
// cells through the memory's read and write ports and writes the last cell in a drain state.
// After reset a clearing pass over all MAX_WIDTH*MAX_HEIGHT cells holds off requests.
// A stalled result port holds one result in the output register and one behind it.
`default_nettype none

module tile_grid_shift_resize import tgsr_pkg::*; #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  logic        clock,
   input  logic        reset,
   tgsr_req_if.sink    req_bus,
   tgsr_rsp_if.source  rsp_bus
);

   localparam int CB    = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
   localparam int RB    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int RQ    = (HW > COORD_W) ? HW : COORD_W;
   localparam int CQ    = (WW > COORD_W) ? WW : COORD_W;
   localparam int AW    = 1 + RB + CB;
   localparam int DEPTH = 1 << AW;

   localparam logic [CB-1:0] COL_LAST = CB'(MAX_WIDTH - 1);
   localparam logic [RB-1:0] ROW_LAST = RB'(MAX_HEIGHT - 1);
   localparam logic [WW-1:0] MAXW_V   = WW'(MAX_WIDTH);
   localparam logic [HW-1:0] MAXH_V   = HW'(MAX_HEIGHT);

   // Grid memory: two banks, each addressed as {row, col}.
   logic [TILE_W-1:0] grid_mem [0:DEPTH-1];
   logic [TILE_W-1:0] rd_data_ff;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [TILE_W-1:0] wr_data;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;

   state_type     state_ff, state_in;
   logic          bank_ff, bank_in;
   logic [WW-1:0] cur_w_ff, cur_w_in;
   logic [HW-1:0] cur_h_ff, cur_h_in;
   logic [RB-1:0] row_ff, row_in;
   logic [CB-1:0] col_ff, col_in;
   logic [WW-1:0] new_w_ff, keep_w_ff;
   logic [HW-1:0] new_h_ff, keep_h_ff;

   logic              p_valid_ff, p_valid_in;
   logic              p_inb_ff;
   logic              rsp_valid_ff;
   logic [TILE_W-1:0] rsp_tile_ff;
   logic              rsp_inb_ff;

   logic          s2_valid_ff, s2_valid_in;
   logic [AW-1:0] s2_addr_ff, s2_addr_in;
   logic          s2_copy_ff, s2_copy_in;

   walk_ctl_type  walk_ctl;
   walk_stat_type walk_stat;
   logic [CB-1:0] src_col;
   logic [RB-1:0] src_row;

   logic          accept;
   logic          out_free;
   logic          p_move;
   logic          post;
   logic          post_inb;
   logic [RB-1:0] row_req;
   logic [CB-1:0] col_req;
   logic          req_inside;
   logic          sweep_last;
   logic          cell_in;
   logic          keep_cell;
   logic [RB-1:0] row_step;
   logic [CB-1:0] col_step;
   logic [WW-1:0] nw;
   logic [HW-1:0] nh;

   // Handshake and pipeline hand-off.
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign p_move        = p_valid_ff && out_free;
   assign req_bus.ready = (state_ff == ST_IDLE) && (!p_valid_ff || out_free);
   assign accept        = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.tile_out  = rsp_tile_ff;
   assign rsp_bus.in_bounds = rsp_inb_ff;
   assign rsp_bus.done_res  = 1'b1;

   // Request position and its bounds check.
   assign row_req    = RB'(req_bus.row);
   assign col_req    = CB'(req_bus.col);
   assign req_inside = (RQ'(req_bus.row) < RQ'(cur_h_ff)) &&
                       (CQ'(req_bus.col) < CQ'(cur_w_ff));

   // Sweep position over the full grid footprint.
   assign sweep_last = (row_ff == ROW_LAST) && (col_ff == COL_LAST);
   assign cell_in    = (HW'(row_ff) < cur_h_ff) && (WW'(col_ff) < cur_w_ff);
   assign keep_cell  = (HW'(row_ff) < keep_h_ff) && (WW'(col_ff) < keep_w_ff);

   always_comb begin
      if (col_ff == COL_LAST) begin
         col_step = '0;
         row_step = (row_ff == ROW_LAST) ? '0 : row_ff + RB'(1);
      end else begin
         col_step = col_ff + CB'(1);
         row_step = row_ff;
      end
   end

   // Resize sizes saturate to the grid limits; zero becomes one.
   always_comb begin
      if (req_bus.new_width == '0) begin
         nw = WW'(1);
      end else if (int'(req_bus.new_width) > MAX_WIDTH) begin
         nw = MAXW_V;
      end else begin
         nw = WW'(req_bus.new_width);
      end
      if (req_bus.new_height == '0) begin
         nh = HW'(1);
      end else if (int'(req_bus.new_height) > MAX_HEIGHT) begin
         nh = MAXH_V;
      end else begin
         nh = HW'(req_bus.new_height);
      end
   end

   // Source coordinate walker for shifts.
   tgsr_src_walk #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_src_walk (
      .clock   (clock),
      .ctl     (walk_ctl),
      .wrap    (req_bus.wrap),
      .shift_x (req_bus.shift_x),
      .shift_y (req_bus.shift_y),
      .width   (cur_w_ff),
      .height  (cur_h_ff),
      .stat    (walk_stat),
      .src_col (src_col),
      .src_row (src_row)
   );

   // Sequencer: drives the memory ports and the sweeps.
   always_comb begin
      state_in    = state_ff;
      bank_in     = bank_ff;
      cur_w_in    = cur_w_ff;
      cur_h_in    = cur_h_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      post        = 1'b0;
      post_inb    = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = {bank_ff, row_req, col_req};
      wr_data     = req_bus.tile_in;
      rd_en       = 1'b0;
      rd_addr     = {bank_ff, row_req, col_req};
      s2_valid_in = 1'b0;
      s2_addr_in  = {~bank_ff, row_ff, col_ff};
      s2_copy_in  = walk_stat.src_ok && cell_in;
      walk_ctl    = '0;

      unique case (state_ff)
         ST_INIT: begin
            wr_en   = 1'b1;
            wr_addr = {bank_ff, row_ff, col_ff};
            wr_data = EMPTY_TILE;
            row_in  = row_step;
            col_in  = col_step;
            if (sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               row_in = '0;
               col_in = '0;
               unique case (req_bus.cmd)
                  CMD_WRITE: begin
                     wr_en = req_inside;
                     post  = 1'b1;
                  end
                  CMD_READ: begin
                     rd_en    = req_inside;
                     post     = 1'b1;
                     post_inb = req_inside;
                  end
                  CMD_SHIFT: begin
                     walk_ctl.load = 1'b1;
                     state_in      = ST_SETUP;
                  end
                  CMD_CLEAR: begin
                     state_in = ST_FILL;
                  end
                  CMD_RESIZE: begin
                     if ((nw == cur_w_ff) && (nh == cur_h_ff)) begin
                        post = 1'b1;
                     end else begin
                        state_in = ST_FILL;
                     end
                  end
                  default: begin
                     post = 1'b1;
                  end
               endcase
            end
         end
         ST_SETUP: begin
            if (walk_stat.settled) begin
               walk_ctl.start = 1'b1;
               state_in       = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            // Read the source cell now, write the destination next cycle.
            rd_en            = s2_copy_in;
            rd_addr          = {bank_ff, src_row, src_col};
            s2_valid_in      = 1'b1;
            walk_ctl.step    = 1'b1;
            walk_ctl.row_end = (col_ff == COL_LAST);
            if (s2_valid_ff) begin
               wr_en   = 1'b1;
               wr_addr = s2_addr_ff;
               wr_data = s2_copy_ff ? rd_data_ff : EMPTY_TILE;
            end
            row_in = row_step;
            col_in = col_step;
            if (sweep_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (s2_valid_ff) begin
               wr_en   = 1'b1;
               wr_addr = s2_addr_ff;
               wr_data = s2_copy_ff ? rd_data_ff : EMPTY_TILE;
            end
            bank_in  = ~bank_ff;
            post     = 1'b1;
            state_in = ST_IDLE;
         end
         ST_FILL: begin
            // Empty every cell outside the kept corner.
            wr_en   = !keep_cell;
            wr_addr = {bank_ff, row_ff, col_ff};
            wr_data = EMPTY_TILE;
            row_in  = row_step;
            col_in  = col_step;
            if (sweep_last) begin
               cur_w_in = new_w_ff;
               cur_h_in = new_h_ff;
               post     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   assign p_valid_in = (p_valid_ff && !out_free) || post;

   // Grid memory ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= grid_mem[rd_addr];
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         bank_ff      <= 1'b0;
         cur_w_ff     <= MAXW_V;
         cur_h_ff     <= MAXH_V;
         row_ff       <= '0;
         col_ff       <= '0;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         s2_valid_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         bank_ff     <= bank_in;
         cur_w_ff    <= cur_w_in;
         cur_h_ff    <= cur_h_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         p_valid_ff  <= p_valid_in;
         s2_valid_ff <= s2_valid_in;
         if (out_free) begin
            rsp_valid_ff <= p_valid_ff;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s2_addr_ff <= s2_addr_in;
      s2_copy_ff <= s2_copy_in;
      if (post) begin
         p_inb_ff <= post_inb;
      end
      if (p_move) begin
         rsp_tile_ff <= p_inb_ff ? rd_data_ff : EMPTY_TILE;
         rsp_inb_ff  <= p_inb_ff;
      end
      // Clear keeps the current size and no cells; resize keeps the overlap when keep is set.
      if (accept) begin
         if (req_bus.cmd == CMD_RESIZE) begin
            new_w_ff  <= nw;
            new_h_ff  <= nh;
            keep_w_ff <= req_bus.keep ? ((nw < cur_w_ff) ? nw : cur_w_ff) : '0;
            keep_h_ff <= req_bus.keep ? ((nh < cur_h_ff) ? nh : cur_h_ff) : '0;
         end else begin
            new_w_ff  <= cur_w_ff;
            new_h_ff  <= cur_h_ff;
            keep_w_ff <= '0;
            keep_h_ff <= '0;
         end
      end
   end

endmodule

`default_nettype wire

@@ design/tgsr_checker.sv @@
`default_nettype none

module tgsr_props import tgsr_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [TILE_W-1:0] rsp_tile_out,
   input logic              rsp_in_bounds,
   input logic              rsp_done_res
);

   // A stalled result keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tile_out) &&
                                  $stable(rsp_in_bounds))
      else $error("result changed while stalled");

   // Every result marks its command as finished.
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_done_res)
      else $error("result without done flag");

   // A result outside the grid or from a non-read command is empty.
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_bounds |-> rsp_tile_out == EMPTY_TILE)
      else $error("out-of-bounds result is not empty");

   // The clearing pass after reset holds off requests; this checks its start, right after reset.
   a_init: assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("request taken during clearing pass");

endmodule

bind tile_grid_shift_resize tgsr_props u_tgsr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_tile_out  (rsp_bus.tile_out),
   .rsp_in_bounds (rsp_bus.in_bounds),
   .rsp_done_res  (rsp_bus.done_res)
);

`default_nettype wire
